FILE: rtl/baa_pkg.sv
// Shared constants, register map and character ramp for the block-average ASCII-art core.
package baa_pkg;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam int MAX_BLOCK_DEF = 64;

  localparam int WIDTH_W  = 13;
  localparam int HEIGHT_W = 16;
  localparam int BSIZE_W  = 7;
  localparam int CHAN_W   = 3;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd3;

  localparam logic [WIDTH_W-1:0]  RST_IMAGE_WIDTH   = 13'd640;
  localparam logic [HEIGHT_W-1:0] RST_IMAGE_HEIGHT  = 16'd480;
  localparam logic [BSIZE_W-1:0]  RST_BLOCK_SIZE    = 7'd8;
  localparam logic [CHAN_W-1:0]   RST_CHANNEL_COUNT = 3'd3;

  // Q16 luma weights, sum is 65536
  localparam logic [15:0] GRAY_W_R = 16'd19595;
  localparam logic [15:0] GRAY_W_G = 16'd38470;
  localparam logic [15:0] GRAY_W_B = 16'd7471;

  localparam logic [6:0] NEWLINE = 7'd10;

  // avg*69/255 == (avg*69*257 + 257) >> 16 for avg in 0..255
  localparam logic [22:0] RAMP_MUL = 23'd17733;
  localparam logic [22:0] RAMP_RND = 23'd257;

  localparam int RAMP_LEN = 70;

  localparam logic [6:0] RAMP [RAMP_LEN] = '{
    7'd36,  7'd64,  7'd66,  7'd37,  7'd56,  7'd38,  7'd87,  7'd77,  7'd35,  7'd42,
    7'd111, 7'd97,  7'd104, 7'd107, 7'd98,  7'd100, 7'd112, 7'd113, 7'd119, 7'd109,
    7'd90,  7'd79,  7'd48,  7'd81,  7'd76,  7'd67,  7'd74,  7'd85,  7'd89,  7'd88,
    7'd122, 7'd99,  7'd118, 7'd117, 7'd110, 7'd120, 7'd114, 7'd106, 7'd102, 7'd116,
    7'd47,  7'd92,  7'd124, 7'd40,  7'd41,  7'd49,  7'd123, 7'd125, 7'd91,  7'd93,
    7'd63,  7'd45,  7'd95,  7'd43,  7'd126, 7'd60,  7'd62,  7'd105, 7'd33,  7'd108,
    7'd73,  7'd59,  7'd58,  7'd44,  7'd34,  7'd94,  7'd96,  7'd39,  7'd46,  7'd32
  };

  function automatic logic [6:0] ramp_code(input logic [7:0] avg);
    logic [22:0] prod;
    prod = 23'(avg) * RAMP_MUL + RAMP_RND;
    return RAMP[prod[22:16]];
  endfunction

endpackage

FILE: rtl/block_average_ascii_art_core.sv
// Top level of the block-average ASCII-art core: counters, block-sum memory, divider, output.
//
// Pixels enter on the s_axis channel in raster order, one 24-bit transfer each
// (first, second, third channel). Characters leave on the m_axis channel: the
// ramp character for each finished block, and a newline after every block row
// but the last; m_axis_tuser marks the final character of the image.
// Registers (width, height, block size, channel count) are written on the cfg
// port; the user must write them only between images or while the core is
// idle; the core does not enforce this. The transfer cycle of each pixel reads
// the column's block sum from the sum memory, and the next cycle adds the gray
// level and writes it back. A pixel that closes a block then runs a restoring
// divide of the SUM_W-bit block sum (20 bits with the default MAX_BLOCK) by
// its pixel count, and its character, with any newline due after it, is loaded
// into the output register once that register is free.
// The output register holds a character until it is taken; while it is full
// and another character is ready, the core waits and s_axis_tready stays low.
// Reset restores the register defaults, clears all position counters and the
// output valid; the sum memory is not cleared (each block overwrites its entry
// on its first pixel), so the core takes pixels from the first cycle after reset.
module block_average_ascii_art_core #(
  parameter int MAX_WIDTH = baa_pkg::MAX_WIDTH_DEF,
  parameter int MAX_BLOCK = baa_pkg::MAX_BLOCK_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [baa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [baa_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [23:0]                    s_axis_tdata,  // chan_first, chan_second, chan_third
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,  // char_code, zero pad
  output logic                           m_axis_tuser   // image_done
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int BLK_W  = $clog2(MAX_BLOCK);
  localparam int SUM_W  = 2 * BLK_W + 8;
  localparam int CNT_W  = 2 * BLK_W + 1;
  localparam int STEP_W = $clog2(SUM_W);
  localparam int WC_W   = (COL_W + 1 > baa_pkg::WIDTH_W) ? COL_W + 1 : baa_pkg::WIDTH_W;
  localparam int BC_W   = (BLK_W + 1 > baa_pkg::BSIZE_W) ? BLK_W + 1 : baa_pkg::BSIZE_W;

  typedef enum logic [2:0] {S_IDLE, S_ADD, S_DIV, S_EMIT, S_NL} state_t;

  state_t state;

  logic [baa_pkg::WIDTH_W-1:0]  image_width;
  logic [baa_pkg::HEIGHT_W-1:0] image_height;
  logic [baa_pkg::BSIZE_W-1:0]  block_size;
  logic [baa_pkg::CHAN_W-1:0]   channel_count;

  logic [COL_W-1:0]            pixel_column;
  logic [baa_pkg::HEIGHT_W-1:0] pixel_line;
  logic [BLK_W-1:0]            line_in_band;
  logic [BLK_W-1:0]            column_in_block;
  logic [COL_W-1:0]            block_column;

  logic [SUM_W-1:0] column_block_sums [MAX_WIDTH];
  logic [SUM_W-1:0] rd_data;
  logic [COL_W-1:0] wr_idx;

  logic [23:0] prod_r, prod_g, prod_b;
  logic [7:0]  red_q;
  logic        direct_q, start_q, emit_q, nl_q, done_q;
  logic [CNT_W-1:0] count_q;

  logic [SUM_W-1:0]  dq;
  logic [CNT_W-1:0]  rem;
  logic [STEP_W-1:0] step;

  // position decode
  logic [WC_W-1:0]  w_ext, w_c, w_m1;
  logic [baa_pkg::HEIGHT_W-1:0] h_m1;
  logic [BC_W-1:0]  bs_ext, bs_c, bs_m1;
  logic line_end, last_line, block_col_end, band_end;
  logic accept, out_free;

  // datapath
  logic [23:0]      psum;
  logic [7:0]       gray_v;
  logic [SUM_W-1:0] new_sum;
  logic [CNT_W:0]   trial, diff;
  logic             ge;
  logic [CNT_W-1:0] rem_next;
  logic [7:0]       avg8;

  always_comb begin
    w_ext = WC_W'(image_width);
    if (w_ext == '0) begin
      w_c = WC_W'(1);
    end else if (w_ext > WC_W'(MAX_WIDTH)) begin
      w_c = WC_W'(MAX_WIDTH);
    end else begin
      w_c = w_ext;
    end
    w_m1 = w_c - WC_W'(1);

    h_m1 = (image_height == '0) ? '0 : image_height - 16'd1;

    bs_ext = BC_W'(block_size);
    if (bs_ext == '0) begin
      bs_c = BC_W'(1);
    end else if (bs_ext > BC_W'(MAX_BLOCK)) begin
      bs_c = BC_W'(MAX_BLOCK);
    end else begin
      bs_c = bs_ext;
    end
    bs_m1 = bs_c - BC_W'(1);

    line_end      = WC_W'(pixel_column) >= w_m1;
    last_line     = pixel_line >= h_m1;
    block_col_end = line_end || (BC_W'(column_in_block) >= bs_m1);
    band_end      = last_line || (BC_W'(line_in_band) >= bs_m1);
  end

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    psum    = prod_r + prod_g + prod_b;
    gray_v  = direct_q ? red_q : psum[23:16];
    new_sum = start_q ? SUM_W'(gray_v) : rd_data + SUM_W'(gray_v);

    trial    = {rem, dq[SUM_W-1]};
    diff     = trial - {1'b0, count_q};
    ge       = trial >= {1'b0, count_q};
    rem_next = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];

    avg8 = (|dq[SUM_W-1:8]) ? 8'hFF : dq[7:0];
  end

  // block-sum memory, one read and one write port, registered read
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= column_block_sums[block_column];
    end
    if (state == S_ADD) begin
      column_block_sums[wr_idx] <= new_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      image_width     <= baa_pkg::RST_IMAGE_WIDTH;
      image_height    <= baa_pkg::RST_IMAGE_HEIGHT;
      block_size      <= baa_pkg::RST_BLOCK_SIZE;
      channel_count   <= baa_pkg::RST_CHANNEL_COUNT;
      pixel_column    <= '0;
      pixel_line      <= '0;
      line_in_band    <= '0;
      column_in_block <= '0;
      block_column    <= '0;
      m_axis_tvalid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          baa_pkg::REG_IMAGE_WIDTH:   image_width   <= cfg_data[baa_pkg::WIDTH_W-1:0];
          baa_pkg::REG_IMAGE_HEIGHT:  image_height  <= cfg_data[baa_pkg::HEIGHT_W-1:0];
          baa_pkg::REG_BLOCK_SIZE:    block_size    <= cfg_data[baa_pkg::BSIZE_W-1:0];
          baa_pkg::REG_CHANNEL_COUNT: channel_count <= cfg_data[baa_pkg::CHAN_W-1:0];
          default: ;
        endcase
      end

      // emit states reload the output register themselves on a transfer
      if (m_axis_tvalid && m_axis_tready && !(state inside {S_EMIT, S_NL})) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            prod_r   <= 24'(s_axis_tdata[7:0])   * 24'(baa_pkg::GRAY_W_R);
            prod_g   <= 24'(s_axis_tdata[15:8])  * 24'(baa_pkg::GRAY_W_G);
            prod_b   <= 24'(s_axis_tdata[23:16]) * 24'(baa_pkg::GRAY_W_B);
            red_q    <= s_axis_tdata[7:0];
            direct_q <= channel_count inside {3'd1, 3'd2};
            start_q  <= (line_in_band == '0) && (column_in_block == '0);
            emit_q   <= block_col_end && band_end;
            nl_q     <= line_end && !last_line;
            done_q   <= line_end && last_line;
            count_q  <= CNT_W'((BLK_W + 1)'(column_in_block) + (BLK_W + 1)'(1))
                        * CNT_W'((BLK_W + 1)'(line_in_band) + (BLK_W + 1)'(1));
            wr_idx   <= block_column;

            if (line_end) begin
              pixel_column    <= '0;
              column_in_block <= '0;
              block_column    <= '0;
              if (last_line) begin
                pixel_line   <= '0;
                line_in_band <= '0;
              end else begin
                pixel_line   <= pixel_line + 16'd1;
                line_in_band <= band_end ? '0 : line_in_band + BLK_W'(1);
              end
            end else begin
              pixel_column <= pixel_column + COL_W'(1);
              if (block_col_end) begin
                column_in_block <= '0;
                block_column <= (block_column == COL_W'(MAX_WIDTH - 1)) ?
                                '0 : block_column + COL_W'(1);
              end else begin
                column_in_block <= column_in_block + BLK_W'(1);
              end
            end
            state <= S_ADD;
          end
        end

        S_ADD: begin
          dq    <= new_sum;
          rem   <= '0;
          step  <= STEP_W'(SUM_W - 1);
          state <= emit_q ? S_DIV : S_IDLE;
        end

        S_DIV: begin
          rem <= rem_next;
          dq  <= {dq[SUM_W-2:0], ge};
          if (step == '0) begin
            state <= S_EMIT;
          end else begin
            step <= step - STEP_W'(1);
          end
        end

        S_EMIT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {1'b0, baa_pkg::ramp_code(avg8)};
            m_axis_tuser  <= done_q;
            state         <= nl_q ? S_NL : S_IDLE;
          end
        end

        S_NL: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {1'b0, baa_pkg::NEWLINE};
            m_axis_tuser  <= 1'b0;
            state         <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/baa_checker.sv
// Port-level checks for the block-average ASCII-art core, bound to the top level.
module baa_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output transfer changed while stalled");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      !m_axis_tdata[7] && (m_axis_tdata[6:0] >= 7'd32 || m_axis_tdata[6:0] == baa_pkg::NEWLINE))
    else $error("output code is neither a ramp character nor newline");

  a_nl_not_done: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[6:0] == baa_pkg::NEWLINE |-> !m_axis_tuser)
    else $error("newline flagged as end of image");

  a_one_pixel: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("pixel taken during read-modify-write of the previous one");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind block_average_ascii_art_core baa_checker u_baa_checker (.*);

FILE: dv/ascii_glyph_checker.sv
`timescale 1ns / 1ps
// Checker for the ASCII-art core: tracks config writes, predicts characters per pixel, compares.
module ascii_glyph_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [baa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [baa_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [23:0]                   s_tdata,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [7:0]                    m_tdata,
  input  logic                          m_tuser,
  output int                            pending,
  output int                            fails
);
  import baa_pkg::*;

  localparam int SUM_DEPTH = MAX_WIDTH_DEF;

  typedef struct packed {
    logic [6:0] code;
    logic       done;
  } glyph_t;

  glyph_t glyph_q[$];

  logic [WIDTH_W-1:0]  img_width;
  logic [HEIGHT_W-1:0] img_height;
  logic [BSIZE_W-1:0]  blk_size;
  logic [CHAN_W-1:0]   chans;

  int unsigned col_sum [SUM_DEPTH];
  logic [11:0] px_col;
  logic [15:0] px_line;
  logic [5:0]  band_line;
  logic [5:0]  cell_col;
  logic [11:0] blk_col;

  int errors = 0;

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= 100) $display("%0t mismatch: %s", $time, what);
  endtask

  function automatic void predict_pixel(input logic [23:0] px);
    int unsigned w, h, bs, gray, cnt, avg;
    bit line_end, last_line, col_end, band_end;
    w = img_width;
    if (w < 1) w = 1;
    if (w > SUM_DEPTH) w = SUM_DEPTH;
    h = img_height;
    if (h < 1) h = 1;
    bs = blk_size;
    if (bs < 1) bs = 1;
    if (bs > MAX_BLOCK_DEF) bs = MAX_BLOCK_DEF;

    if (chans == 1 || chans == 2)
      gray = px[7:0];
    else
      gray = (int'(GRAY_W_R) * px[7:0] + int'(GRAY_W_G) * px[15:8]
              + int'(GRAY_W_B) * px[23:16]) >> 16;

    if (band_line == 0 && cell_col == 0)
      col_sum[blk_col] = gray;
    else
      col_sum[blk_col] += gray;

    line_end  = px_col >= w - 1;
    last_line = px_line >= h - 1;
    col_end   = line_end || cell_col >= bs - 1;
    band_end  = last_line || band_line >= bs - 1;

    if (col_end && band_end) begin
      cnt = (int'(cell_col) + 1) * (int'(band_line) + 1);
      avg = col_sum[blk_col] / cnt;
      // stale sums after a mid-band block change can push this past full scale
      if (avg > 255) avg = 255;
      glyph_q.push_back(glyph_t'{code: RAMP[avg * 69 / 255], done: line_end && last_line});
      if (line_end && !last_line)
        glyph_q.push_back(glyph_t'{code: NEWLINE, done: 1'b0});
    end

    if (line_end) begin
      px_col   = '0;
      cell_col = '0;
      blk_col  = '0;
      if (last_line) begin
        px_line   = '0;
        band_line = '0;
      end else begin
        px_line++;
        band_line = band_end ? '0 : band_line + 1'b1;
      end
    end else begin
      px_col++;
      if (col_end) begin
        cell_col = '0;
        blk_col++;
      end else begin
        cell_col++;
      end
    end
  endfunction

  always @(posedge clk) begin : watch
    glyph_t want;
    if (rst) begin
      img_width  = RST_IMAGE_WIDTH;
      img_height = RST_IMAGE_HEIGHT;
      blk_size   = RST_BLOCK_SIZE;
      chans      = RST_CHANNEL_COUNT;
      px_col     = '0;
      px_line    = '0;
      band_line  = '0;
      cell_col   = '0;
      blk_col    = '0;
      glyph_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:   img_width  = cfg_data[WIDTH_W-1:0];
          REG_IMAGE_HEIGHT:  img_height = cfg_data[HEIGHT_W-1:0];
          REG_BLOCK_SIZE:    blk_size   = cfg_data[BSIZE_W-1:0];
          REG_CHANNEL_COUNT: chans      = cfg_data[CHAN_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) predict_pixel(s_tdata);
      if (m_tvalid && m_tready) begin
        if (glyph_q.size() == 0) begin
          report_mismatch($sformatf("unexpected char 0x%02h", m_tdata));
        end else begin
          want = glyph_q.pop_front();
          if (m_tdata !== {1'b0, want.code})
            report_mismatch($sformatf("char 0x%02h, expected 0x%02h", m_tdata, want.code));
          if (m_tuser !== want.done)
            report_mismatch($sformatf("image_done %b, expected %b on char 0x%02h",
                                      m_tuser, want.done, want.code));
        end
      end
    end
    pending <= glyph_q.size();
    fails   <= errors;
  end

endmodule

FILE: dv/block_average_ascii_art_core_test.sv
`timescale 1ns / 1ps
// Testbench top for the ASCII-art core: clock, reset, config writes, pixel and character traffic.
module block_average_ascii_art_core_test;
  import baa_pkg::*;

  localparam int HALF_PERIOD = 10;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYC  = 40;
  localparam int HOLD_CYC    = 300;
  localparam int PIXEL_GOAL  = 850;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [23:0]          s_tdata   = '0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [7:0]           m_tdata;
  logic                 m_tuser;

  int          pending;
  int          fails;
  int unsigned cycles      = 0;
  int          pixels_sent = 0;
  int          hold_req    = 0;

  // no idling on either side in this window
  wire calm = cycles >= 2000 && cycles < 5000;

  always #HALF_PERIOD clk = ~clk;

  block_average_ascii_art_core u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser)
  );

  ascii_glyph_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .pending   (pending),
    .fails     (fails)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // character sink; a hold request stalls it long enough to back up the input
  initial begin : sink
    int hold_seen;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        m_tready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk);
      end
      m_tready <= calm || $urandom_range(99) >= 15;
    end
  end

  task automatic push_pixel(input logic [23:0] px);
    while (!calm && $urandom_range(99) < 15) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pixels_sent++;
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_image(input int unsigned w, h, bs, ch);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_BLOCK_SIZE, bs);
    write_reg(REG_CHANNEL_COUNT, ch);
  endtask

  function automatic logic [23:0] pick_pixel();
    logic [23:0] px;
    px = 24'($urandom);
    if ($urandom_range(7) == 0)
      for (int k = 0; k < 3; k++) px[8*k +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
    return px;
  endfunction

  initial begin : stim
    int unsigned w, h, bs, ew, eh, total, cut;
    int img;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults (640x480, 8-pixel blocks, RGB), then end the image early
    repeat (4) push_pixel(pick_pixel());
    settle();
    write_reg(REG_IMAGE_HEIGHT, 1);
    write_reg(REG_IMAGE_WIDTH, 12);
    repeat (8) push_pixel(pick_pixel());
    settle();

    // four channels use the weighted sum, two channels only the first
    set_image(4, 1, 1, 4);
    push_pixel(24'hFFFFFF);
    push_pixel(24'h000000);
    push_pixel(24'h0000FF);
    push_pixel(24'hFF0000);
    settle();
    set_image(2, 1, 1, 2);
    push_pixel(24'hFFFF00);
    push_pixel(24'h0000FF);
    settle();

    // shrink the block mid-band: stale sums over a small count saturate
    set_image(2, 65535, 4, 1);
    repeat (2) push_pixel(24'h0000FF);
    settle();
    write_reg(REG_BLOCK_SIZE, 1);
    repeat (2) push_pixel(24'h0000FF);
    settle();
    write_reg(REG_IMAGE_HEIGHT, 1);
    repeat (2) push_pixel(pick_pixel());
    settle();

    // widest line and tallest image, clamped width, cut short mid-line
    set_image(4096, 65535, 8, 7);
    repeat (3) push_pixel(pick_pixel());
    settle();
    write_reg(REG_IMAGE_HEIGHT, 1);
    write_reg(REG_IMAGE_WIDTH, 8191);
    repeat (5) push_pixel(pick_pixel());
    settle();
    write_reg(REG_IMAGE_WIDTH, 10);
    repeat (2) push_pixel(pick_pixel());
    settle();

    img = 0;
    while (pixels_sent < PIXEL_GOAL) begin
      w  = ($urandom_range(99) < 5) ? 0 : $urandom_range(1, 24);
      h  = ($urandom_range(99) < 5) ? 0 : $urandom_range(1, 8);
      case ($urandom_range(19))
        0:       bs = 0;
        1:       bs = 64;
        2:       bs = 127;
        default: bs = $urandom_range(1, 6);
      endcase
      if (img == 2) begin
        w  = 10;
        h  = 6;
        bs = 1;
        hold_req++;
      end
      set_image(w, h, bs, $urandom_range(7));
      ew    = (w == 0) ? 1 : w;
      eh    = (h == 0) ? 1 : h;
      total = ew * eh;
      cut   = (eh > 1 && $urandom_range(99) < 20) ? $urandom_range(1, total - 1) : total;
      repeat (cut) push_pixel(pick_pixel());
      if (cut != total) begin
        // drop the height so the current line ends the image
        settle();
        write_reg(REG_IMAGE_HEIGHT, 1);
        repeat (ew - cut % ew) push_pixel(pick_pixel());
      end
      settle();
      img++;
    end

    if (fails == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: files.f
rtl/baa_pkg.sv
rtl/block_average_ascii_art_core.sv
rtl/baa_checker.sv
dv/ascii_glyph_checker.sv
dv/block_average_ascii_art_core_test.sv
